// ----- rtl/core/circular_double_ended_queue_core_macros.svh -----
// Assertion macros for the deque core.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define CDQ_ASSERT_NOW(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) \
      else $error("deque core check failed");

// The consequent must hold in the cycle after the trigger.
`define CDQ_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("deque core check failed");

`endif

// ----- rtl/core/cdq_pkg.sv -----
// Shared sizes, codes, types and value conversions for the deque core.
// No dependencies; every other file of the core but the assertion macros imports it.
package cdq_pkg;

   localparam int DEPTH = 8;
   localparam int DATA_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_DEPTH = COUNT_WIDTH'(DEPTH);

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_LOWER,
      CELL_FROM_UPPER,
      CELL_FROM_VALUE
   } cell_sel_type;

   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_INSERT,
      CHAIN_REMOVE,
      CHAIN_APPEND
   } chain_mode_type;

   typedef struct packed {
      chain_mode_type         mode;
      logic [COUNT_WIDTH-1:0] count;
      logic [DATA_WIDTH-1:0]  value;
   } chain_ctrl_type;

   function automatic logic [DATA_WIDTH-1:0] to_slot(input logic [31:0] v);
      logic [63:0] w;
      w = {32'b0, v};
      return w[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] from_slot(input logic [DATA_WIDTH-1:0] s);
      logic signed [DATA_WIDTH-1:0] ss;
      logic [63:0] w;
      ss = s;
      w = 64'(ss);
      return w[31:0];
   endfunction

endpackage

// ----- rtl/core/cdq_channels.sv -----
// Valid/ready channel interfaces for the deque core's command and response words.
// Depends on cdq_pkg.
interface cdq_req_if import cdq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink (input valid, input command, input push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] popped_value;
   logic               is_empty;
   logic               is_full;

   modport source (output valid, output status, output popped_value,
                   output is_empty, output is_full, input ready);
   modport sink (input valid, input status, input popped_value,
                 input is_empty, input is_full, output ready);
endinterface

// ----- rtl/core/cdq_cell.sv -----
// One storage cell of a deque chain: holds a slot and loads from a neighbor or the input.
// Depends on cdq_pkg.
module cdq_cell import cdq_pkg::*; (
   input  logic                  clock,
   input  cell_sel_type          sel,
   input  logic [DATA_WIDTH-1:0] lower_data,
   input  logic [DATA_WIDTH-1:0] upper_data,
   input  logic [DATA_WIDTH-1:0] value,
   output logic [DATA_WIDTH-1:0] data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      unique case (sel)
         CELL_FROM_LOWER: data_in = lower_data;
         CELL_FROM_UPPER: data_in = upper_data;
         CELL_FROM_VALUE: data_in = value;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/core/cdq_chain.sv -----
// A row of cells holding the queue in order from cell zero, with shift and append moves.
// Depends on cdq_pkg and cdq_cell.
module cdq_chain import cdq_pkg::*; (
   input  logic                  clock,
   input  chain_ctrl_type        ctrl,
   output logic [DATA_WIDTH-1:0] head
);

   logic [DATA_WIDTH-1:0] data [DEPTH];
   cell_sel_type          sel [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         unique case (ctrl.mode)
            CHAIN_INSERT: sel[i] = CELL_FROM_LOWER;
            CHAIN_REMOVE: sel[i] = CELL_FROM_UPPER;
            CHAIN_APPEND: sel[i] = (ctrl.count == COUNT_WIDTH'(i)) ? CELL_FROM_VALUE
                                                                    : CELL_HOLD;
            default:      sel[i] = CELL_HOLD;
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_data;
      logic [DATA_WIDTH-1:0] upper_data;

      if (g == 0) begin : g_first
         assign lower_data = ctrl.value;
      end else begin : g_inner_low
         assign lower_data = data[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign upper_data = data[g];
      end else begin : g_inner_high
         assign upper_data = data[g+1];
      end

      cdq_cell u_cell (
         .clock      (clock),
         .sel        (sel[g]),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .value      (ctrl.value),
         .data       (data[g])
      );
   end

   assign head = data[0];

endmodule

// ----- rtl/core/circular_double_ended_queue_core.sv -----
// Double-ended queue of DEPTH entries: push or pop at either end, one command word per
// cycle, one response word per command. The response is registered in the cycle after its
// command is accepted, and a new command is taken in the same cycle as the response is
// taken, so the single response register sustains one word per cycle while responses are
// taken. The contents are kept in two cell chains in opposite order, so the front and the
// rear entry each sit in the first cell of a chain. No clearing pass follows reset.
// Depends on cdq_pkg, cdq_channels, cdq_chain and the assertion macros.
`include "circular_double_ended_queue_core_macros.svh"

module circular_double_ended_queue_core import cdq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   cdq_req_if.sink   req_port,
   cdq_rsp_if.source rsp_port
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   status_type             status_ff;
   status_type             status_in;
   logic [31:0]            popped_ff;
   logic [31:0]            popped_in;
   logic                   empty_ff;
   logic                   full_ff;

   logic                   accept;
   logic                   is_push;
   cmd_type                cmd;
   chain_ctrl_type         front_ctrl;
   chain_ctrl_type         rear_ctrl;
   logic [DATA_WIDTH-1:0]  front_head;
   logic [DATA_WIDTH-1:0]  rear_head;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept = req_port.valid && req_port.ready;
   assign cmd = cmd_type'(req_port.command);
   assign is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);

   always_comb begin
      front_ctrl.mode  = CHAIN_HOLD;
      front_ctrl.count = count_ff;
      front_ctrl.value = to_slot(req_port.push_value);
      rear_ctrl        = front_ctrl;
      count_in         = count_ff;
      status_in        = STATUS_DONE;
      popped_in        = 32'd0;
      if (accept) begin
         unique case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
               if (count_ff == COUNT_DEPTH) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + COUNT_WIDTH'(1);
                  if (cmd == CMD_PUSH_FRONT) begin
                     front_ctrl.mode = CHAIN_INSERT;
                     rear_ctrl.mode  = CHAIN_APPEND;
                  end else begin
                     front_ctrl.mode = CHAIN_APPEND;
                     rear_ctrl.mode  = CHAIN_INSERT;
                  end
               end
            end
            default: begin
               if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - COUNT_WIDTH'(1);
                  if (cmd == CMD_POP_FRONT) begin
                     front_ctrl.mode = CHAIN_REMOVE;
                     popped_in = from_slot(front_head);
                  end else begin
                     rear_ctrl.mode = CHAIN_REMOVE;
                     popped_in = from_slot(rear_head);
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   cdq_chain u_front_chain (
      .clock (clock),
      .ctrl  (front_ctrl),
      .head  (front_head)
   );

   cdq_chain u_rear_chain (
      .clock (clock),
      .ctrl  (rear_ctrl),
      .head  (rear_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in == COUNT_DEPTH);
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = status_ff;
   assign rsp_port.popped_value = popped_ff;
   assign rsp_port.is_empty     = empty_ff;
   assign rsp_port.is_full      = full_ff;

   `CDQ_ASSERT_NOW(a_count_range, 1'b1, count_ff <= COUNT_DEPTH)
   `CDQ_ASSERT_NEXT(a_full_refusal, accept && is_push, (status_ff == STATUS_FULL) == ($past(count_ff) == COUNT_DEPTH))
   `CDQ_ASSERT_NEXT(a_pop_count, accept && !is_push && (count_ff != '0), count_ff == $past(count_ff) - COUNT_WIDTH'(1))
   `CDQ_ASSERT_NOW(a_flags_match, rsp_valid_ff, (empty_ff == (count_ff == '0)) && (full_ff == (count_ff == COUNT_DEPTH)))

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for circular_double_ended_queue_core: directed and random command
// words against an in-bench deque predictor, with random idling and back-pressure.
// Depends on cdq_pkg, cdq_channels and the core itself.
`timescale 1ns / 1ps

module testbench;
   import cdq_pkg::*;

   typedef struct {
      cmd_type     command;
      logic [31:0] value;
      bit          drain_first;
   } command_word_type;

   typedef struct {
      status_type  status;
      logic [31:0] popped;
      logic        is_empty;
      logic        is_full;
   } response_word_type;

   logic clock;
   logic reset;

   cdq_req_if req_if ();
   cdq_rsp_if rsp_if ();

   circular_double_ended_queue_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   command_word_type  pending_words[$];
   response_word_type expected_responses[$];

   logic [DATA_WIDTH-1:0] deque_slots [DEPTH];
   int deque_head;
   int deque_tail;
   bit deque_empty;

   int words_sent;
   int words_received;
   int total_words;
   int failures;
   int send_gap;
   int recv_gap;
   int hold_left;
   bit hold_done;

   int pushes_done;
   int pops_done;
   int refused_full;
   int refused_empty;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int next_index(input int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int prev_index(input int i);
      return (i == 0) ? DEPTH - 1 : i - 1;
   endfunction

   function automatic bit deque_is_full();
      return !deque_empty && deque_head == next_index(deque_tail);
   endfunction

   function automatic response_word_type predict_response(input cmd_type c,
                                                          input logic [31:0] v);
      response_word_type r;
      logic [63:0] wide;
      logic signed [DATA_WIDTH-1:0] entry;
      int at;
      wide = {32'b0, v};
      r.status = STATUS_DONE;
      r.popped = '0;
      if (c == CMD_PUSH_FRONT || c == CMD_PUSH_REAR) begin
         if (deque_is_full()) begin
            r.status = STATUS_FULL;
            refused_full++;
         end else begin
            if (deque_empty) begin
               deque_head = 0;
               deque_tail = 0;
               deque_empty = 1'b0;
               at = 0;
            end else if (c == CMD_PUSH_FRONT) begin
               deque_head = prev_index(deque_head);
               at = deque_head;
            end else begin
               deque_tail = next_index(deque_tail);
               at = deque_tail;
            end
            deque_slots[at] = wide[DATA_WIDTH-1:0];
            pushes_done++;
         end
      end else begin
         if (deque_empty) begin
            r.status = STATUS_EMPTY;
            refused_empty++;
         end else begin
            at = (c == CMD_POP_FRONT) ? deque_head : deque_tail;
            entry = deque_slots[at];
            r.popped = 32'(entry);
            if (deque_head == deque_tail) begin
               deque_head = 0;
               deque_tail = 0;
               deque_empty = 1'b1;
            end else if (c == CMD_POP_FRONT) begin
               deque_head = next_index(deque_head);
            end else begin
               deque_tail = prev_index(deque_tail);
            end
            pops_done++;
         end
      end
      r.is_empty = deque_empty;
      r.is_full = deque_is_full();
      return r;
   endfunction

   function automatic bit idle_allowed(input int count);
      return count < total_words - 250 && (count / 150) % 3 != 2;
   endfunction

   task automatic report_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   task automatic add_word(input cmd_type c, input logic [31:0] v, input bit drain);
      command_word_type w;
      w.command = c;
      w.value = v;
      w.drain_first = drain;
      pending_words.push_back(w);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Driver: offers the pending words and predicts each one as it is taken.
   always @(posedge clock) begin
      bit next_valid;
      command_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_responses.push_back(
               predict_response(cmd_type'(req_if.command), req_if.push_value));
            words_sent <= words_sent + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() != 0) begin
               if (pending_words[0].drain_first && expected_responses.size() != 0) begin
                  next_valid = 1'b0;
               end else if (idle_allowed(words_sent) && $urandom_range(0, 9) == 0) begin
                  send_gap = $urandom_range(0, 5);
               end else begin
                  w = pending_words.pop_front();
                  req_if.command <= w.command;
                  req_if.push_value <= w.value;
                  next_valid = 1'b1;
               end
            end
            req_if.valid <= next_valid;
         end
      end
   end

   // Monitor: checks each response word against the oldest prediction.
   always @(posedge clock) begin
      response_word_type e;
      bit next_ready;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            words_received <= words_received + 1;
            if (expected_responses.size() == 0) begin
               report_failure($sformatf("unexpected response status=%0d popped=%h",
                                        rsp_if.status, rsp_if.popped_value));
            end else begin
               e = expected_responses.pop_front();
               if (rsp_if.status !== e.status || rsp_if.popped_value !== e.popped ||
                   rsp_if.is_empty !== e.is_empty || rsp_if.is_full !== e.is_full) begin
                  report_failure($sformatf(
                     {"mismatch: expected status=%0d popped=%h empty=%b full=%b, ",
                      "got status=%0d popped=%h empty=%b full=%b"},
                     e.status, e.popped, e.is_empty, e.is_full, rsp_if.status,
                     rsp_if.popped_value, rsp_if.is_empty, rsp_if.is_full));
               end
            end
         end
         next_ready = 1'b1;
         if (hold_left != 0) begin
            next_ready = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
         end else if (idle_allowed(words_received) && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 5);
            next_ready = 1'b0;
         end
         rsp_if.ready <= next_ready;
      end
   end

   // A single long hold-off on the response side while commands keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_sent >= 400) begin
         hold_left <= 80;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin
      #1000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      int push_bias;
      cmd_type c;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_PUSH_FRONT;
      req_if.push_value = '0;
      rsp_if.ready = 1'b0;
      words_sent = 0;
      words_received = 0;
      failures = 0;
      pushes_done = 0;
      pops_done = 0;
      refused_full = 0;
      refused_empty = 0;
      deque_head = 0;
      deque_tail = 0;
      deque_empty = 1'b1;

      add_word(CMD_POP_FRONT, 32'hFFFF_FFFF, 1'b0);
      add_word(CMD_POP_REAR, 32'h0000_0000, 1'b0);
      add_word(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0);
      add_word(CMD_POP_REAR, 32'h0000_0000, 1'b0);
      add_word(CMD_PUSH_REAR, 32'h8000_0000, 1'b0);
      add_word(CMD_PUSH_FRONT, 32'h0000_0000, 1'b0);
      add_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < DEPTH - 3; i++) begin
         add_word(CMD_PUSH_REAR, pick_value(), 1'b0);
      end
      add_word(CMD_PUSH_FRONT, 32'h1234_5678, 1'b0);
      add_word(CMD_PUSH_REAR, 32'h8765_4321, 1'b0);
      for (int i = 0; i < DEPTH; i++) begin
         add_word(cmd_type'((i % 2 == 0) ? CMD_POP_FRONT : CMD_POP_REAR), $urandom, 1'b0);
      end
      add_word(CMD_POP_FRONT, 32'h0000_0000, 1'b0);

      // The random walk leans toward pushing or popping in stretches so the queue
      // keeps swinging between empty and full, wrapping the indices on the way.
      push_bias = 50;
      for (int i = 0; i < 2000; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: push_bias = 20;
               1: push_bias = 50;
               default: push_bias = 80;
            endcase
         end
         if ($urandom_range(1, 100) <= push_bias) begin
            c = cmd_type'($urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT);
         end else begin
            c = cmd_type'($urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT);
         end
         add_word(c, pick_value(), i == 1000 || i == 1600);
      end
      total_words = pending_words.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_if.valid || expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (expected_responses.size() != 0) begin
         report_failure($sformatf("%0d responses never arrived", expected_responses.size()));
      end

      $display("Ran %0d command words: %0d pushes and %0d pops done,", words_sent,
               pushes_done, pops_done);
      $display("%0d refused as full, %0d as empty, %0d failures.", refused_full,
               refused_empty, failures);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
